FILE: rtl/core/spd_pkg.sv
package spd_pkg;

  // Request field widths
  localparam int OP_W  = 2;
  localparam int IDX_W = 8;
  localparam int LEN_W = 13;
  localparam int ST_W  = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PUT,
    S_LOOK,
    S_DONE
  } spd_state_t;

  // Finished result handed from the sequencer to the output register
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [LEN_W-1:0] offset;
    logic [LEN_W-1:0] free_bytes;
  } spd_res_t;

endpackage

FILE: rtl/core/spd_ram.sv
module spd_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, read one entry with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/spd_ctrl.sv
module spd_ctrl
  import spd_pkg::*;
#(
  parameter int PAGE_BYTES   = 4096,
  parameter int MAX_SLOTS    = 256,
  parameter int HEADER_BYTES = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [OP_W-1:0]  in_operation,
  input  logic [IDX_W-1:0] in_slot_index,
  input  logic [LEN_W-1:0] in_length,
  output logic             in_stall,
  output logic             res_valid,
  output spd_res_t         res,
  input  logic             res_take
);

  localparam int DW  = $clog2(PAGE_BYTES + 1);
  localparam int SW  = $clog2(MAX_SLOTS + 1);
  localparam int AW  = $clog2(MAX_SLOTS);
  localparam int CW  = (SW > IDX_W) ? SW : IDX_W;
  localparam int XW0 = (DW > SW + 6) ? DW : SW + 6;
  localparam int XW  = ((XW0 > LEN_W + 1) ? XW0 : LEN_W + 1) + 1;

  spd_state_t       state_r, state_nxt;
  logic [SW-1:0]    total_r, total_nxt;
  logic [DW-1:0]    dstart_r, dstart_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    k_r, k_nxt;
  logic [ST_W-1:0]  status_r, status_nxt;
  logic [LEN_W-1:0] offset_r, offset_nxt;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [LEN_W-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [LEN_W-1:0] rdata;

  logic [CW-1:0]    idx_c, total_c;
  logic [AW-1:0]    idx_a, total_a;
  logic [XW-1:0]    len_x, dstart_x, used_x, free_x, newds_x;

  spd_ram #(
    .WIDTH(LEN_W),
    .DEPTH(MAX_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Align operands to common widths
  assign idx_c    = CW'(in_slot_index);
  assign total_c  = CW'(total_r);
  assign idx_a    = idx_c[AW-1:0];
  assign total_a  = total_c[AW-1:0];
  assign len_x    = XW'(in_length);
  assign dstart_x = XW'(dstart_r);

  // Free space between directory end and data start, floored at zero
  assign used_x  = XW'(HEADER_BYTES) + (XW'(total_r) << 1);
  assign free_x  = (dstart_x < used_x) ? '0 : dstart_x - used_x;
  assign newds_x = dstart_x - len_x;

  assign in_stall       = (state_r != S_IDLE);
  assign res_valid      = (state_r == S_DONE);
  assign res.status     = status_r;
  assign res.offset     = offset_r;
  assign res.free_bytes = free_x[LEN_W-1:0];

  // Hold state and directory registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      total_r  <= '0;
      dstart_r <= DW'(PAGE_BYTES);
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      dstart_r <= dstart_nxt;
    end
  end

  // Payload registers of the request in flight
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    k_r      <= k_nxt;
    status_r <= status_nxt;
    offset_r <= offset_nxt;
  end

  // Sequence one request: decide, shift the directory, place or read
  always_comb begin
    state_nxt  = state_r;
    total_nxt  = total_r;
    dstart_nxt = dstart_r;
    idx_nxt    = idx_r;
    k_nxt      = k_r;
    status_nxt = status_r;
    offset_nxt = offset_r;
    we         = 1'b0;
    waddr      = k_r;
    wdata      = rdata;
    raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          status_nxt = ST_OK;
          offset_nxt = '0;
          idx_nxt    = idx_a;
          state_nxt  = S_DONE;
          unique case (in_operation)
            OP_CLEAR: begin
              if ((len_x > XW'(PAGE_BYTES)) || (len_x < XW'(HEADER_BYTES))) begin
                status_nxt = ST_BAD;
              end else begin
                total_nxt  = '0;
                dstart_nxt = len_x[DW-1:0];
              end
            end
            OP_INSERT: begin
              if ((idx_c > total_c) || (total_r >= SW'(MAX_SLOTS))) begin
                status_nxt = ST_BAD;
              end else if (free_x < len_x + XW'(2)) begin
                status_nxt = ST_NOSPACE;
              end else begin
                dstart_nxt = newds_x[DW-1:0];
                offset_nxt = newds_x[LEN_W-1:0];
                if (idx_c == total_c) begin
                  // Append: no entries to move
                  we        = 1'b1;
                  waddr     = idx_a;
                  wdata     = newds_x[LEN_W-1:0];
                  total_nxt = total_r + SW'(1);
                end else begin
                  // Open a gap: start reading the last entry
                  raddr     = total_a - AW'(1);
                  k_nxt     = total_a;
                  state_nxt = S_SHIFT;
                end
              end
            end
            OP_LOOKUP: begin
              if (idx_c >= total_c) begin
                status_nxt = ST_BAD;
              end else begin
                raddr     = idx_a;
                state_nxt = S_LOOK;
              end
            end
            default: begin
              status_nxt = ST_BAD;
            end
          endcase
        end
      end
      S_SHIFT: begin
        // Move entry k-1 up to k, fetch the next one down
        we    = 1'b1;
        waddr = k_r;
        wdata = rdata;
        if ((k_r - AW'(1)) == idx_r) begin
          state_nxt = S_PUT;
        end else begin
          raddr = k_r - AW'(2);
          k_nxt = k_r - AW'(1);
        end
      end
      S_PUT: begin
        // Store the new record offset in the gap
        we        = 1'b1;
        waddr     = idx_r;
        wdata     = offset_r;
        total_nxt = total_r + SW'(1);
        state_nxt = S_DONE;
      end
      S_LOOK: begin
        offset_nxt = rdata;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/slotted_page_directory_unit.sv
// Channel   Ports                                             Direction
// input     in_valid, in_stall, in_operation, in_slot_index,  request in
//           in_length
// result    out_valid, out_stall, out_status, out_offset,     result out
//           out_free_bytes
//
// One request at a time. Clear, rejected requests and appends go straight
// to the result; a lookup first reads the slot RAM, and an insert at index i
// with n entries first moves n - i entries up: the directory shift does one
// RAM read and one write per cycle through the single-write slot RAM.
// rst_n is synchronous, active low; it empties the directory and sets the
// data start to the page end. The slot RAM itself is not cleared.
// A stalled result waits in the output register while the next request is
// taken in and worked on.
module slotted_page_directory_unit
  import spd_pkg::*;
#(
  parameter int PAGE_BYTES   = 4096,
  parameter int MAX_SLOTS    = 256,
  parameter int HEADER_BYTES = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [OP_W-1:0]  in_operation,
  input  logic [IDX_W-1:0] in_slot_index,
  input  logic [LEN_W-1:0] in_length,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ST_W-1:0]  out_status,
  output logic [LEN_W-1:0] out_offset,
  output logic [LEN_W-1:0] out_free_bytes
);

  logic     res_valid;
  logic     res_take;
  spd_res_t res;
  logic     out_valid_r, out_valid_nxt;
  spd_res_t out_r;

  spd_ctrl #(
    .PAGE_BYTES  (PAGE_BYTES),
    .MAX_SLOTS   (MAX_SLOTS),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_slot_index(in_slot_index),
    .in_length    (in_length),
    .in_stall     (in_stall),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (res_take)
  );

  // Load the output register when it is empty or being drained
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_offset     = out_r.offset;
  assign out_free_bytes = out_r.free_bytes;

`ifndef SYNTH
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while one is in flight");

  a_out_from_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(res_valid))
    else $error("output register loaded without a finished request");

  a_err_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_offset == '0))
    else $error("nonzero offset on an error result");
`endif

endmodule

FILE: test/tb_slotted_page_directory_unit.sv
`timescale 1ns / 100ps

module tb_slotted_page_directory_unit;
  import spd_pkg::*;

  localparam int PAGE_SIZE = 4096;
  localparam int DIR_SLOTS = 256;
  localparam int HDR_SIZE  = 6;
  localparam int LEN_MAX   = (1 << LEN_W) - 1;
  localparam int SETTLE_CYCLES = 300;
  localparam int DRAIN_GUARD   = 5000;

  // Operation code the block does not define
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [OP_W-1:0]  in_operation;
  logic [IDX_W-1:0] in_slot_index;
  logic [LEN_W-1:0] in_length;
  logic             out_valid;
  logic             out_stall;
  logic [ST_W-1:0]  out_status;
  logic [LEN_W-1:0] out_offset;
  logic [LEN_W-1:0] out_free_bytes;

  // Page state mirrored by the predictor
  logic [LEN_W-1:0] dir_offset [DIR_SLOTS];
  int               dir_count;
  int               data_top;

  spd_res_t page_results [$];
  bit       idle_on;
  int       fail_count;
  int       req_count;
  int       result_count;
  int       op_seen [4];
  int       status_seen [4];

  slotted_page_directory_unit #(
    .PAGE_BYTES   (PAGE_SIZE),
    .MAX_SLOTS    (DIR_SLOTS),
    .HEADER_BYTES (HDR_SIZE)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_slot_index  (in_slot_index),
    .in_length      (in_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_offset     (out_offset),
    .out_free_bytes (out_free_bytes)
  );

  always #6 clk = ~clk;

  // Free bytes between the end of the directory and the data start
  function automatic int page_room();
    int used;
    used = HDR_SIZE + 2 * dir_count;
    return (data_top < used) ? 0 : data_top - used;
  endfunction

  // Apply one request to the mirrored page and return the expected result
  function automatic spd_res_t apply_page_request(logic [OP_W-1:0] op,
                                                  logic [IDX_W-1:0] idx,
                                                  logic [LEN_W-1:0] len);
    spd_res_t r;
    int       k;
    r.status = ST_OK;
    r.offset = '0;
    case (op)
      OP_CLEAR: begin
        if (int'(len) > PAGE_SIZE || int'(len) < HDR_SIZE) begin
          r.status = ST_BAD;
        end else begin
          dir_count = 0;
          data_top  = int'(len);
        end
      end
      OP_INSERT: begin
        if (int'(idx) > dir_count || dir_count >= DIR_SLOTS) begin
          r.status = ST_BAD;
        end else if (page_room() < int'(len) + 2) begin
          r.status = ST_NOSPACE;
        end else begin
          data_top = data_top - int'(len);
          for (k = dir_count; k > int'(idx); k--)
            dir_offset[IDX_W'(k)] = dir_offset[IDX_W'(k - 1)];
          dir_offset[idx] = data_top[LEN_W-1:0];
          dir_count++;
          r.offset = data_top[LEN_W-1:0];
        end
      end
      OP_LOOKUP: begin
        if (int'(idx) >= dir_count) begin
          r.status = ST_BAD;
        end else begin
          r.offset = dir_offset[idx];
        end
      end
      default: r.status = ST_BAD;
    endcase
    r.free_bytes = LEN_W'(page_room());
    return r;
  endfunction

  // Present one request, hold it until taken, then queue its expected result
  task automatic send_request(input logic [OP_W-1:0] op, input int idx, input int len);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_slot_index <= IDX_W'(idx);
    in_length     <= LEN_W'(len);
    do @(posedge clk); while (in_stall);
    page_results.push_back(apply_page_request(op, IDX_W'(idx), LEN_W'(len)));
    req_count++;
    op_seen[op]++;
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic wait_results_drained();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (page_results.size() != 0 && waited < DRAIN_GUARD);
    if (page_results.size() != 0) begin
      $error("%0d results never arrived", page_results.size());
      fail_count++;
      page_results.delete();
    end
  endtask

  task automatic send_bad_page_size();
    if ($urandom_range(0, 1) != 0)
      send_request(OP_CLEAR, $urandom, $urandom_range(0, HDR_SIZE - 1));
    else
      send_request(OP_CLEAR, $urandom, $urandom_range(PAGE_SIZE + 1, LEN_MAX));
  endtask

  // Empty directory after reset: every lookup, an insert past the end and an undefined op are rejected
  task automatic test_empty_page();
    send_request(OP_LOOKUP, 0, 0);
    send_request(OP_LOOKUP, 255, 0);
    send_request(OP_INSERT, 1, 0);
    send_request(OP_UNUSED, 255, LEN_MAX);
  endtask

  // Page sizes beyond both limits and at the lower one, and the smallest usable page
  task automatic test_page_size_limits();
    send_request(OP_CLEAR, 0, HDR_SIZE - 1);
    send_request(OP_CLEAR, 0, PAGE_SIZE + 1);
    send_request(OP_CLEAR, 0, LEN_MAX);
    send_request(OP_CLEAR, 0, HDR_SIZE);
    send_request(OP_INSERT, 0, 0);
    send_request(OP_CLEAR, 0, HDR_SIZE + 2);
    send_request(OP_INSERT, 0, 0);
  endtask

  // Free space boundary, including the room taken by the new pointer
  task automatic test_space_check();
    send_request(OP_CLEAR, 0, PAGE_SIZE);
    send_request(OP_INSERT, 0, PAGE_SIZE - HDR_SIZE - 3);
    send_request(OP_INSERT, 0, LEN_MAX);
    send_request(OP_INSERT, 0, PAGE_SIZE - HDR_SIZE - 4);
    send_request(OP_INSERT, 0, 0);
    send_request(OP_INSERT, 1, 0);
    send_request(OP_LOOKUP, 0, 0);
    send_request(OP_LOOKUP, 1, 0);
    send_request(OP_LOOKUP, 2, 0);
    send_request(OP_INSERT, 3, 0);
  endtask

  // Fill every slot, then try one more
  task automatic test_directory_full();
    int n;
    send_request(OP_CLEAR, 0, PAGE_SIZE);
    for (n = 0; n < DIR_SLOTS; n++) begin
      send_request(OP_INSERT, (n == DIR_SLOTS - 1) ? 255 : $urandom_range(0, n),
                   $urandom_range(0, 13));
      if (n % 16 == 15) send_request(OP_LOOKUP, $urandom_range(0, n), 0);
    end
    send_request(OP_INSERT, 0, 0);
    send_request(OP_INSERT, 255, 0);
    send_request(OP_LOOKUP, 255, 0);
    send_request(OP_LOOKUP, 0, 0);
  endtask

  // Pause the sender with work outstanding, then resume
  task automatic test_drain_pause();
    send_request(OP_CLEAR, 0, PAGE_SIZE);
    repeat (6) send_request(OP_INSERT, 0, $urandom_range(0, 40));
    wait_results_drained();
    send_request(OP_LOOKUP, 5, 0);
    send_request(OP_INSERT, 3, 17);
    wait_results_drained();
  endtask

  // Page sessions: a clear followed by random inserts, lookups, undefined ops and further clears
  task automatic test_random_pages(input int budget, input bit allow_idle);
    int start, steps, pick, room, top_idx, idx, len;
    start = req_count;
    while (req_count - start < budget) begin
      idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) send_bad_page_size();
      else if (pick == 1) send_request(OP_CLEAR, $urandom, $urandom_range(HDR_SIZE, 64));
      else if (pick == 2) send_request(OP_CLEAR, $urandom, PAGE_SIZE);
      else send_request(OP_CLEAR, $urandom, $urandom_range(65, PAGE_SIZE));
      steps = $urandom_range(8, 120);
      while (steps > 0 && req_count - start < budget) begin
        steps--;
        pick = $urandom_range(0, 99);
        room = page_room();
        if (pick < 55) begin
          top_idx = (dir_count > 255) ? 255 : dir_count;
          idx = ($urandom_range(0, 9) != 0) ? $urandom_range(0, top_idx)
                                            : $urandom_range(0, 255);
          case ($urandom_range(0, 9))
            0:       len = $urandom_range(0, LEN_MAX);
            1:       len = (room < 4) ? $urandom_range(0, 4)
                                      : $urandom_range(room - 4, room + 1);
            2, 3:    len = $urandom_range(0, room);
            default: len = $urandom_range(0, 24);
          endcase
          send_request(OP_INSERT, idx, len);
        end else if (pick < 92) begin
          idx = (dir_count > 0 && $urandom_range(0, 7) != 0)
                ? $urandom_range(0, dir_count - 1) : $urandom_range(0, 255);
          send_request(OP_LOOKUP, idx, $urandom);
        end else if (pick < 95) begin
          send_request(OP_UNUSED, $urandom, $urandom);
        end else if (pick < 98) begin
          send_bad_page_size();
        end else begin
          send_request(OP_CLEAR, $urandom, $urandom_range(HDR_SIZE, PAGE_SIZE));
        end
        if ($urandom_range(0, 299) == 0) wait_results_drained();
      end
    end
  endtask

  // Receiver stalls in random bursts while idling is on
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest expected one
  always @(posedge clk) begin
    spd_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      status_seen[out_status]++;
      if (page_results.size() == 0) begin
        $error("unexpected result: status %0d offset %0d free_bytes %0d",
               out_status, out_offset, out_free_bytes);
        fail_count++;
      end else begin
        want = page_results.pop_front();
        if (out_status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_offset !== want.offset) begin
          $error("offset mismatch: expected %0d, got %0d", want.offset, out_offset);
          fail_count++;
        end
        if (out_free_bytes !== want.free_bytes) begin
          $error("free_bytes mismatch: expected %0d, got %0d",
                 want.free_bytes, out_free_bytes);
          fail_count++;
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_operation  <= OP_CLEAR;
    in_slot_index <= '0;
    in_length     <= '0;
    idle_on       = 1'b0;
    fail_count    = 0;
    req_count     = 0;
    result_count  = 0;
    dir_count     = 0;
    data_top      = PAGE_SIZE;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    idle_on = 1'b1;
    test_empty_page();
    test_page_size_limits();
    test_space_check();
    test_directory_full();
    test_drain_pause();
    test_random_pages(1450, 1'b1);
    idle_on = 1'b0;
    test_random_pages(300, 1'b0);

    // Let the block settle, then catch any stray result
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d clears, %0d inserts, %0d lookups, %0d undefined ops",
             req_count, op_seen[OP_CLEAR], op_seen[OP_INSERT], op_seen[OP_LOOKUP],
             op_seen[OP_UNUSED]);
    $display("Checked %0d results: %0d ok, %0d rejected, %0d out of space, %0d errors",
             result_count, status_seen[ST_OK], status_seen[ST_BAD],
             status_seen[ST_NOSPACE], fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
